// ----- hw/rtl/mt19937_word_generator_assert.svh -----
// Assertion macros shared by the word generator RTL.
// Used by mtwg_front and mtwg_engine; expects clk_i and rst_ni in scope.
`ifndef MT19937_WORD_GENERATOR_ASSERT_SVH
`define MT19937_WORD_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MTWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define MTWG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define MTWG_ASSERT(lbl, prop, msg)
`define MTWG_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/mtwg_pkg.sv -----
// Shared types and constants of the MT19937 word generator.
// No dependencies; used by mtwg_front, mtwg_engine and the top level.
`timescale 1ns / 1ps
`default_nettype none
package mtwg_pkg;

  localparam int unsigned StateWords   = 624;
  localparam int unsigned MiddleOffset = 397;
  localparam int unsigned IdxW         = 10;

  localparam logic [IdxW-1:0] LastIdx     = IdxW'(StateWords - 1);
  localparam logic [IdxW-1:0] FullIdx     = IdxW'(StateWords);
  localparam logic [IdxW-1:0] UnseededIdx = IdxW'(StateWords + 1);
  localparam logic [IdxW-1:0] MidIdx      = IdxW'(MiddleOffset);
  localparam logic [IdxW-1:0] MidWrapIdx  = IdxW'(StateWords - MiddleOffset);

  localparam logic [31:0] SeedMult    = 32'd1812433253;
  localparam logic [31:0] TwistMatrix = 32'h9908b0df;
  localparam logic [31:0] TemperB     = 32'h9d2c5680;
  localparam logic [31:0] TemperC     = 32'hefc60000;
  localparam logic [31:0] SeedDefault = 32'd5489;

  // Request as seen at the head of the queue.
  typedef struct packed {
    logic valid;
    logic reseed;
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_TW_PRIME,
    ST_TW_LOAD,
    ST_TW_RD,
    ST_TW_WR,
    ST_READ,
    ST_READ_WAIT
  } engine_state_e;

endpackage
`default_nettype wire

// ----- hw/rtl/mtwg_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mtwg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mtwg_front.sv -----
// Front end: accepts requests and holds them in a short queue.
// Depends on mtwg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mt19937_word_generator_assert.svh"
module mtwg_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          reseed_i,
  output mtwg_pkg::req_t     req_o,
  input  wire logic          pop_i
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [DEPTH-1:0] fifo_q;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;

  assign in_ready_o   = (count_q != FullCnt);
  assign push         = in_valid_i && in_ready_o;
  assign req_o.valid  = (count_q != '0);
  assign req_o.reseed = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= reseed_i;
    end
  end

  `MTWG_ASSERT(a_count_bound, count_q <= FullCnt, "queue count above depth")
  `MTWG_ASSERT_NEVER(a_pop_empty, pop_i && (count_q == '0), "pop from empty queue")
  `MTWG_ASSERT(a_count_up, (push && !pop_i) |=> (count_q == $past(count_q) + 1'b1),
               "queue count did not advance on push")

endmodule
`default_nettype wire

// ----- hw/rtl/mtwg_engine.sv -----
// Back end: seeding, twisting and tempered readout over the word store.
// Depends on mtwg_pkg and the assertion macro header; drives an mtwg_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "mt19937_word_generator_assert.svh"
module mtwg_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [31:0]                  seed_i,
  input  mtwg_pkg::req_t                    req_i,
  output logic                              pop_o,
  output logic                              ram_we_o,
  output logic      [mtwg_pkg::IdxW-1:0]    ram_waddr_o,
  output logic      [31:0]                  ram_wdata_o,
  output logic      [mtwg_pkg::IdxW-1:0]    ram_raddr_a_o,
  output logic      [mtwg_pkg::IdxW-1:0]    ram_raddr_b_o,
  input  wire logic [31:0]                  ram_rdata_a_i,
  input  wire logic [31:0]                  ram_rdata_b_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [31:0]                  random_word_o
);

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & mtwg_pkg::TemperB);
    y = y ^ ((y << 15) & mtwg_pkg::TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  mtwg_pkg::engine_state_e state_q, state_d;
  logic [mtwg_pkg::IdxW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [31:0] prev_q, prev_d, prod_q, prod_d, cur_q, cur_d, word_q, word_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic [31:0] seed_word, mix, twist_y, twist_w;

  assign out_free      = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign random_word_o = word_q;

  assign mix       = prev_q ^ (prev_q >> 30);
  assign seed_word = prod_q + 32'(cnt_q);
  assign twist_y   = {cur_q[31], ram_rdata_a_i[30:0]};
  assign twist_w   = ram_rdata_b_i ^ (twist_y >> 1)
                   ^ (twist_y[0] ? mtwg_pkg::TwistMatrix : 32'd0);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    prev_d        = prev_q;
    prod_d        = prod_q;
    cur_d         = cur_q;
    word_d        = word_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    pop_o         = 1'b0;
    ram_we_o      = 1'b0;
    ram_waddr_o   = cnt_q;
    ram_wdata_o   = seed_word;
    ram_raddr_a_o = idx_q;
    ram_raddr_b_o = cnt_q;
    unique case (state_q)
      mtwg_pkg::ST_IDLE: begin
        if (req_i.valid && out_free) begin
          pop_o = 1'b1;
          if (req_i.reseed || (idx_q == mtwg_pkg::UnseededIdx)) begin
            state_d = mtwg_pkg::ST_SEED_INIT;
          end else if (idx_q == mtwg_pkg::FullIdx) begin
            state_d = mtwg_pkg::ST_TW_PRIME;
          end else begin
            state_d = mtwg_pkg::ST_READ;
          end
        end
      end
      mtwg_pkg::ST_SEED_INIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = '0;
        ram_wdata_o = seed_i;
        prev_d      = seed_i;
        cnt_d       = mtwg_pkg::IdxW'(1);
        state_d     = mtwg_pkg::ST_SEED_MUL;
      end
      mtwg_pkg::ST_SEED_MUL: begin
        prod_d  = mix * mtwg_pkg::SeedMult;
        state_d = mtwg_pkg::ST_SEED_WR;
      end
      mtwg_pkg::ST_SEED_WR: begin
        ram_we_o = 1'b1;
        prev_d   = seed_word;
        if (cnt_q == mtwg_pkg::LastIdx) begin
          state_d = mtwg_pkg::ST_TW_PRIME;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = mtwg_pkg::ST_SEED_MUL;
        end
      end
      mtwg_pkg::ST_TW_PRIME: begin
        ram_raddr_a_o = '0;
        state_d       = mtwg_pkg::ST_TW_LOAD;
      end
      mtwg_pkg::ST_TW_LOAD: begin
        cur_d   = ram_rdata_a_i;
        cnt_d   = '0;
        state_d = mtwg_pkg::ST_TW_RD;
      end
      mtwg_pkg::ST_TW_RD: begin
        ram_raddr_a_o = (cnt_q == mtwg_pkg::LastIdx) ? '0 : cnt_q + 1'b1;
        ram_raddr_b_o = (cnt_q < mtwg_pkg::MidWrapIdx) ? cnt_q + mtwg_pkg::MidIdx
                                                       : cnt_q - mtwg_pkg::MidWrapIdx;
        state_d       = mtwg_pkg::ST_TW_WR;
      end
      mtwg_pkg::ST_TW_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = twist_w;
        cur_d       = ram_rdata_a_i;
        if (cnt_q == mtwg_pkg::LastIdx) begin
          idx_d   = '0;
          state_d = mtwg_pkg::ST_READ;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = mtwg_pkg::ST_TW_RD;
        end
      end
      mtwg_pkg::ST_READ: begin
        state_d = mtwg_pkg::ST_READ_WAIT;
      end
      mtwg_pkg::ST_READ_WAIT: begin
        word_d      = temper(ram_rdata_a_i);
        out_valid_d = 1'b1;
        idx_d       = idx_q + 1'b1;
        state_d     = mtwg_pkg::ST_IDLE;
      end
      default: begin
        state_d = mtwg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtwg_pkg::ST_IDLE;
      idx_q       <= mtwg_pkg::UnseededIdx;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    prod_q <= prod_d;
    cur_q  <= cur_d;
    word_q <= word_d;
  end

  `MTWG_ASSERT(a_read_in_range, (state_q == mtwg_pkg::ST_READ) |-> (idx_q < mtwg_pkg::FullIdx),
               "readout index past the store")
  `MTWG_ASSERT(a_out_from_read, $rose(out_valid_q) |-> $past(state_q == mtwg_pkg::ST_READ_WAIT),
               "result appeared outside readout")
  `MTWG_ASSERT(a_out_slot_free, (state_q == mtwg_pkg::ST_READ_WAIT) |-> !out_valid_q,
               "result would overwrite a waiting result")
  `MTWG_ASSERT(a_write_in_range, ram_we_o |-> (ram_waddr_o < mtwg_pkg::FullIdx),
               "store write past the last word")

endmodule
`default_nettype wire

// ----- hw/rtl/mt19937_word_generator.sv -----
// When the store holds unread words, a request passes ST_IDLE, ST_READ and
// ST_READ_WAIT before its tempered result is registered. Every 624th word
// adds a store regeneration (one RAM read pair and one write per step); a
// seeding pass precedes it on a reseed. A new request is taken only in ST_IDLE.
// Reset: asynchronous, active low; the store reads as unseeded, seed is 5489.
`timescale 1ns / 1ps
`default_nettype none
module mt19937_word_generator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // seed register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] seed_i,
  // word request
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        reseed_i,
  // word result
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      random_word_o
);

  logic [31:0]               seed_q;
  mtwg_pkg::req_t            req;
  logic                      pop;
  logic                      ram_we;
  logic [mtwg_pkg::IdxW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [31:0]               ram_wdata, ram_rdata_a, ram_rdata_b;

  // The seed register always takes a write; it only matters at the next seeding.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mtwg_pkg::SeedDefault;
    end else if (cfg_valid_i) begin
      seed_q <= seed_i;
    end
  end

  // Front: hold incoming requests so the requester waits on the twist only once the queue is full.
  mtwg_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .reseed_i   (reseed_i),
    .req_o      (req),
    .pop_i      (pop)
  );

  // Back: seed, twist and temper; one request drained per produced word.
  mtwg_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_i        (seed_q),
    .req_i         (req),
    .pop_o         (pop),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .ram_rdata_a_i (ram_rdata_a),
    .ram_rdata_b_i (ram_rdata_b),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .random_word_o (random_word_o)
  );

  // 624-word state store; port B serves only the middle tap of the twist.
  mtwg_ram #(
    .WIDTH (32),
    .DEPTH (mtwg_pkg::StateWords)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking bench for mt19937_word_generator: random requests, seed writes, flow control.
// Depends on mtwg_pkg and the generator RTL; a scoreboard class predicts each tempered word.
`timescale 1ns / 1ps
module tb;

  localparam logic [31:0] HighBit    = 32'h8000_0000;
  localparam logic [31:0] LowBits    = 32'h7fff_ffff;
  localparam int unsigned CycleLimit = 1_000_000;

  // Scoreboard: private copy of the generator's word store, read position and
  // seed register. Each accepted request pushes the word that it must return.
  class mt_stream_scoreboard;
    logic [31:0] twister_words [mtwg_pkg::StateWords];
    int unsigned next_pos;
    logic [31:0] seed_value;
    logic [31:0] expected_words [$];
    int unsigned mismatches;

    function new();
      foreach (twister_words[i]) twister_words[i] = '0;
      next_pos   = mtwg_pkg::StateWords + 1;  // unseeded after reset
      seed_value = mtwg_pkg::SeedDefault;
      mismatches = 0;
    endfunction

    function void set_seed(logic [31:0] value);
      seed_value = value;
    endfunction

    function void note_request(bit want_reseed);
      logic [31:0] prev;
      logic [31:0] mixed;
      logic [31:0] word;
      int unsigned nxt;
      int unsigned mid;
      // Rebuild the store on reseed or on the first request after reset.
      if (want_reseed || next_pos >= mtwg_pkg::StateWords + 1) begin
        twister_words[0] = seed_value;
        for (int unsigned i = 1; i < mtwg_pkg::StateWords; i++) begin
          prev = twister_words[i-1];
          twister_words[i] = mtwg_pkg::SeedMult * (prev ^ (prev >> 30)) + i;
        end
        next_pos = mtwg_pkg::StateWords;
      end
      // Regenerate all words in place once the store is used up.
      if (next_pos >= mtwg_pkg::StateWords) begin
        for (int unsigned k = 0; k < mtwg_pkg::StateWords; k++) begin
          nxt   = (k + 1) % mtwg_pkg::StateWords;
          mid   = (k + mtwg_pkg::MiddleOffset) % mtwg_pkg::StateWords;
          mixed = (twister_words[k] & HighBit) | (twister_words[nxt] & LowBits);
          word  = twister_words[mid] ^ (mixed >> 1);
          if (mixed[0]) word = word ^ mtwg_pkg::TwistMatrix;
          twister_words[k] = word;
        end
        next_pos = 0;
      end
      word = twister_words[next_pos];
      next_pos++;
      word = word ^ (word >> 11);
      word = word ^ ((word << 7) & mtwg_pkg::TemperB);
      word = word ^ ((word << 15) & mtwg_pkg::TemperC);
      word = word ^ (word >> 18);
      expected_words.push_back(word);
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected random_word, expected none, got %08h", $time, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        $display("%0t: random_word mismatch, expected %08h, got %08h", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] seed_i      = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        reseed_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] random_word_o;

  // Idle odds in percent; changed between phases, read every cycle.
  int unsigned request_gap_pct = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned cycle_count     = 0;

  mt_stream_scoreboard board = new();

  mt19937_word_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .seed_i        (seed_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .reseed_i      (reseed_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .random_word_o (random_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hold reset at the start, then release it for good.
  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: give up once the run is far past its slowest correct length.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Result side: check what was taken at this edge, then pick the next ready.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) board.check_word(random_word_o);
      out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Drive one request, with random gaps before it; note it once accepted.
  task automatic issue_request(input bit want_reseed);
    while (request_gap_pct != 0 && $urandom_range(99) < request_gap_pct) begin
      in_valid_i <= 1'b0;
      reseed_i   <= 1'($urandom);  // noise while no request is offered
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    reseed_i   <= want_reseed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(want_reseed);
  endtask

  // Stop requesting and wait until every predicted word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the seed register; only called with the generator drained.
  task automatic write_seed(input logic [31:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    seed_i      <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_seed(value);
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase; reseed_odds of 0 keeps the stream running unbroken.
  task automatic run_phase(input int unsigned count, input int unsigned gap_pct,
                           input int unsigned stall_pct, input int unsigned reseed_odds);
    bit want_reseed;
    request_gap_pct = gap_pct;
    ready_stall_pct = stall_pct;
    for (int unsigned n = 0; n < count; n++) begin
      want_reseed = (reseed_odds != 0) && ($urandom_range(reseed_odds - 1) == 0);
      // Now and then let the pipeline run completely dry.
      if (gap_pct != 0 && $urandom_range(47) == 0) drain_results();
      issue_request(want_reseed);
    end
  endtask

  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Directed: first request seeds from the default, reseed mid-stream.
    issue_request(1'b0);
    issue_request(1'b0);
    issue_request(1'b0);
    issue_request(1'b1);
    issue_request(1'b0);
    issue_request(1'b0);
    // A new seed must not disturb the running stream until a reseed.
    write_seed(32'h0000_0000);
    issue_request(1'b0);
    issue_request(1'b1);
    issue_request(1'b0);
    // All-ones seed, back-to-back reseeds.
    write_seed(32'hffff_ffff);
    issue_request(1'b1);
    issue_request(1'b0);
    issue_request(1'b1);
    issue_request(1'b1);
    write_seed($urandom);
    issue_request(1'b0);
    issue_request(1'b1);
    issue_request(1'b0);

    // Random: the first three phases never reseed, so the stream keeps
    // running across the seed writes between them, which must stay deferred.
    run_phase(120, 0, 0, 0);
    write_seed($urandom);
    run_phase(120, 71, 0, 0);
    write_seed(mtwg_pkg::SeedDefault);
    run_phase(120, 0, 71, 0);
    write_seed($urandom);
    run_phase(120, 34, 34, 6);

    // Let everything drain, then allow a tail for stray results.
    drain_results();
    repeat (16) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
